/* rtl/vrt_pkg.sv */
package vrt_pkg;

    localparam int MAX_STEPS_DEF = 256;

    localparam logic [31:0] ALL32  = 32'hFFFF_FFFF;
    localparam logic [30:0] MASK31 = 31'h7FFF_FFFF;
    localparam logic [31:0] MIN_SQ = 32'd11;

    // divider: 33-bit dividend, 16-bit divisor
    localparam int DIV_NW = 33;
    localparam int DIV_DW = 16;
    // root: 64-bit radicand, 32-bit root
    localparam int ROOT_W = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_CHECK,
        ST_ROOT,
        ST_DT_GO,
        ST_DT_WAIT,
        ST_MUL,
        ST_DN_GO,
        ST_DN_WAIT,
        ST_EMIT,
        ST_STEP
    } vrt_state_t;

    typedef struct packed {
        logic load_start;
        logic take_answer;
        logic sq_acc;
        logic root_start;
        logic axis_clr;
        logic axis_adv;
        logic div_start_step;
        logic div_start_next;
        logic wr_step;
        logic wr_next;
        logic mul_g;
        logic out_miss;
        logic out_query;
        logic step_exec;
    } vrt_cmd_t;

    typedef struct packed {
        logic sum_small;
        logic root_done;
        logic div_done;
        logic axis_last;
        logic walking;
        logic out_free;
    } vrt_stat_t;

endpackage

/* rtl/vrt_isqrt.sv */
module vrt_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [31:0]                 sum,
    output logic                        done,
    output logic [vrt_pkg::ROOT_W-1:0]  root
);
    import vrt_pkg::*;

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 4;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    // one result bit per cycle, two radicand bits brought down
    always_comb
    begin
        rem_sh    = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {{(REM_W-ROOT_W-2){1'b0}}, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            rad_next  = {sum, 32'd0};
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* rtl/vrt_div.sv */
module vrt_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [vrt_pkg::DIV_NW-1:0]  num,
    input  logic [vrt_pkg::DIV_DW-1:0]  den,
    output logic                        done,
    output logic [vrt_pkg::DIV_NW-1:0]  quot
);
    import vrt_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] q_reg, q_next;
    logic [DIV_DW-1:0] d_reg, d_next;
    logic [DIV_DW:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DIV_DW+1:0] rem_sh;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_sh    = {rem_reg, q_reg[DIV_NW-1]};
        q_next    = q_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            q_next    = num;
            d_next    = den;
            rem_next  = '0;
            cnt_next  = CNT_W'(DIV_NW);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {2'b00, d_reg})
            begin
                rem_next = (DIV_DW+1)'(rem_sh - {2'b00, d_reg});
                q_next   = {q_reg[DIV_NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DIV_DW:0];
                q_next   = {q_reg[DIV_NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

/* rtl/vrt_dp.sv */
module vrt_dp #(
    parameter int MAX_STEPS = vrt_pkg::MAX_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  vrt_pkg::vrt_cmd_t   cmd,
    output vrt_pkg::vrt_stat_t  stat,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic signed [15:0]  dir_x,
    input  logic signed [15:0]  dir_y,
    input  logic signed [15:0]  dir_z,
    input  logic [30:0]         max_dist,
    input  logic                solid,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                done_res,
    output logic signed [15:0]  voxel_x,
    output logic signed [15:0]  voxel_y,
    output logic signed [15:0]  voxel_z,
    output logic signed [1:0]   face_x,
    output logic signed [1:0]   face_y,
    output logic signed [1:0]   face_z,
    output logic                hit,
    output logic [30:0]         distance
);
    import vrt_pkg::*;

    localparam int SW = $clog2(MAX_STEPS + 1);

    // ray setup and walk state
    logic [15:0]        frac_reg [3];
    logic signed [15:0] dir_reg [3];
    logic [30:0]        limit_reg;
    logic [31:0]        sum_reg;
    logic [31:0]        len_reg;
    logic [DIV_NW-1:0]  prod_reg;
    logic [1:0]         axis_reg;
    logic               solid_reg;
    logic [15:0]        vox_reg [3];
    logic               sign_reg [3];
    logic [31:0]        tnext_reg [3];
    logic [31:0]        tstep_reg [3];
    logic signed [1:0]  norm_reg [3];
    logic [SW-1:0]      steps_reg;
    logic               walking_reg;

    // result register
    logic               out_valid_reg;
    logic               done_res_reg;
    logic [15:0]        ovox_reg [3];
    logic signed [1:0]  oface_reg [3];
    logic               hit_reg;
    logic [30:0]        dist_reg;

    logic signed [15:0] d_sel;
    logic signed [31:0] d_sq;
    logic [15:0]        ad_sel;
    logic [16:0]        g_sel;
    logic [48:0]        g_prod;
    logic               root_done;
    logic [31:0]        root;
    logic               div_start;
    logic [DIV_NW-1:0]  div_num;
    logic               div_done;
    logic [DIV_NW-1:0]  quot;
    logic [31:0]        quot_sat;
    logic               out_free;

    logic [1:0]         sel;
    logic [31:0]        t_min;
    logic [32:0]        t_sum;
    logic [31:0]        t_adv;
    logic [15:0]        vox_adv;
    logic               beyond;
    logic               budget_out;

    // per-axis setup operands
    always_comb
    begin
        d_sel    = dir_reg[axis_reg];
        d_sq     = d_sel * d_sel;
        ad_sel   = d_sel[15] ? 16'(-d_sel) : d_sel;
        g_sel    = (d_sel > 0) ? (17'h10000 - {1'b0, frac_reg[axis_reg]})
                               : {1'b0, frac_reg[axis_reg]};
        g_prod   = {32'd0, g_sel} * {17'd0, len_reg};
        quot_sat = quot[DIV_NW-1] ? ALL32 : quot[31:0];
        div_start = cmd.div_start_step | cmd.div_start_next;
        div_num  = cmd.div_start_step ? {1'b0, len_reg} : prod_reg;
    end

    vrt_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.root_start),
        .sum   (sum_reg),
        .done  (root_done),
        .root  (root)
    );

    vrt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (ad_sel),
        .done  (div_done),
        .quot  (quot)
    );

    // pick the nearest boundary; ties go to z over y, and y over x
    always_comb
    begin
        if (tnext_reg[0] < tnext_reg[1])
        begin
            sel = (tnext_reg[0] < tnext_reg[2]) ? 2'd0 : 2'd2;
        end
        else
        begin
            sel = (tnext_reg[1] < tnext_reg[2]) ? 2'd1 : 2'd2;
        end
        t_min      = tnext_reg[sel];
        t_sum      = {1'b0, t_min} + {1'b0, tstep_reg[sel]};
        t_adv      = t_sum[32] ? ALL32 : t_sum[31:0];
        vox_adv    = sign_reg[sel] ? (vox_reg[sel] + 16'd1) : (vox_reg[sel] - 16'd1);
        beyond     = t_min > {1'b0, limit_reg};
        budget_out = steps_reg >= SW'(MAX_STEPS);
        out_free   = !out_valid_reg || out_ready;
    end

    // setup and walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_start)
        begin
            frac_reg[0] <= pos_x[15:0];
            frac_reg[1] <= pos_y[15:0];
            frac_reg[2] <= pos_z[15:0];
            dir_reg[0]  <= dir_x;
            dir_reg[1]  <= dir_y;
            dir_reg[2]  <= dir_z;
            limit_reg   <= max_dist;
            sum_reg     <= '0;
        end
        if (cmd.sq_acc)
        begin
            sum_reg <= sum_reg + 32'(unsigned'(d_sq));
        end
        if (root_done && cmd.axis_clr)
        begin
            len_reg <= root;
        end
        if (cmd.mul_g)
        begin
            prod_reg <= g_prod[48:16];
        end
        if (cmd.take_answer)
        begin
            solid_reg <= solid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg    <= '0;
            steps_reg   <= '0;
            walking_reg <= 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                vox_reg[a]   <= '0;
                sign_reg[a]  <= 1'b0;
                tnext_reg[a] <= ALL32;
                tstep_reg[a] <= ALL32;
                norm_reg[a]  <= '0;
            end
        end
        else
        begin
            if (cmd.load_start || cmd.axis_clr)
            begin
                axis_reg <= '0;
            end
            else if (cmd.sq_acc || cmd.axis_adv)
            begin
                axis_reg <= axis_reg + 2'd1;
            end
            if (cmd.load_start)
            begin
                vox_reg[0]  <= pos_x[31:16];
                vox_reg[1]  <= pos_y[31:16];
                vox_reg[2]  <= pos_z[31:16];
                sign_reg[0] <= dir_x > 0;
                sign_reg[1] <= dir_y > 0;
                sign_reg[2] <= dir_z > 0;
                steps_reg   <= '0;
                walking_reg <= 1'b0;
                for (int a = 0; a < 3; a++)
                begin
                    tnext_reg[a] <= ALL32;
                    tstep_reg[a] <= ALL32;
                    norm_reg[a]  <= '0;
                end
            end
            if (cmd.wr_step)
            begin
                tstep_reg[axis_reg] <= (d_sel == 0) ? ALL32 : quot_sat;
            end
            if (cmd.wr_next)
            begin
                tnext_reg[axis_reg] <= (d_sel == 0) ? ALL32 : quot_sat;
            end
            if (cmd.out_query)
            begin
                walking_reg <= 1'b1;
                steps_reg   <= SW'(1);
            end
            if (cmd.out_miss)
            begin
                walking_reg <= 1'b0;
            end
            if (cmd.step_exec)
            begin
                if (solid_reg || beyond)
                begin
                    walking_reg <= 1'b0;
                end
                else
                begin
                    vox_reg[sel]   <= vox_adv;
                    tnext_reg[sel] <= t_adv;
                    // entry face opposes the step on the crossed axis only
                    for (int a = 0; a < 3; a++)
                    begin
                        norm_reg[a] <= (2'(a) != sel) ? 2'sb00
                                     : (sign_reg[sel] ? 2'sb11 : 2'sb01);
                    end
                    if (budget_out)
                    begin
                        walking_reg <= 1'b0;
                    end
                    else
                    begin
                        steps_reg <= steps_reg + SW'(1);
                    end
                end
            end
        end
    end

    // result register: load a query, a miss or a final result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_miss || cmd.out_query || cmd.step_exec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_miss || (cmd.step_exec && !solid_reg && (beyond || budget_out)))
        begin
            done_res_reg <= 1'b1;
            hit_reg      <= 1'b0;
            dist_reg     <= limit_reg;
            for (int a = 0; a < 3; a++)
            begin
                ovox_reg[a]  <= '0;
                oface_reg[a] <= '0;
            end
        end
        else if (cmd.out_query)
        begin
            done_res_reg <= 1'b0;
            hit_reg      <= 1'b0;
            dist_reg     <= '0;
            for (int a = 0; a < 3; a++)
            begin
                ovox_reg[a]  <= vox_reg[a];
                oface_reg[a] <= '0;
            end
        end
        else if (cmd.step_exec && solid_reg)
        begin
            done_res_reg <= 1'b1;
            hit_reg      <= !beyond;
            dist_reg     <= t_min[31] ? MASK31 : t_min[30:0];
            for (int a = 0; a < 3; a++)
            begin
                ovox_reg[a]  <= vox_reg[a];
                oface_reg[a] <= norm_reg[a];
            end
        end
        else if (cmd.step_exec)
        begin
            done_res_reg <= 1'b0;
            hit_reg      <= 1'b0;
            dist_reg     <= '0;
            for (int a = 0; a < 3; a++)
            begin
                ovox_reg[a]  <= (2'(a) == sel) ? vox_adv : vox_reg[a];
                oface_reg[a] <= '0;
            end
        end
    end

    assign stat.sum_small = sum_reg < MIN_SQ;
    assign stat.root_done = root_done;
    assign stat.div_done  = div_done;
    assign stat.axis_last = axis_reg == 2'd2;
    assign stat.walking   = walking_reg;
    assign stat.out_free  = out_free;

    assign out_valid = out_valid_reg;
    assign done_res  = done_res_reg;
    assign voxel_x   = ovox_reg[0];
    assign voxel_y   = ovox_reg[1];
    assign voxel_z   = ovox_reg[2];
    assign face_x    = oface_reg[0];
    assign face_y    = oface_reg[1];
    assign face_z    = oface_reg[2];
    assign hit       = hit_reg;
    assign distance  = dist_reg;

    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= SW'(MAX_STEPS))
        else $error("step count beyond budget");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_miss || cmd.out_query || cmd.step_exec) |-> out_free)
        else $error("result loaded over a pending transfer");

    a_walk_steps: assert property (@(posedge clk) disable iff (!rst_n)
        walking_reg |-> (steps_reg != '0))
        else $error("walking with no step counted");

    a_tstep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        walking_reg |-> (tstep_reg[0] != '0 && tstep_reg[1] != '0 && tstep_reg[2] != '0))
        else $error("zero boundary spacing while walking");

endmodule

/* rtl/vrt_ctrl.sv */
module vrt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                op,
    output logic                in_ready,
    input  vrt_pkg::vrt_stat_t  stat,
    output vrt_pkg::vrt_cmd_t   cmd
);
    import vrt_pkg::*;

    vrt_state_t state_reg, state_next;
    logic       in_xfer;

    assign in_ready = state_reg == ST_IDLE;
    assign in_xfer  = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = op ? ST_STEP : ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (stat.axis_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!stat.sum_small)
                begin
                    state_next = ST_ROOT;
                end
                else if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ROOT:
            begin
                if (stat.root_done)
                begin
                    state_next = ST_DT_GO;
                end
            end
            ST_DT_GO:   state_next = ST_DT_WAIT;
            ST_DT_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:     state_next = ST_DN_GO;
            ST_DN_GO:   state_next = ST_DN_WAIT;
            ST_DN_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = stat.axis_last ? ST_EMIT : ST_DT_GO;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_STEP:
            begin
                if (!stat.walking || stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_start  = in_xfer && !op;
                cmd.take_answer = in_xfer && op;
            end
            ST_SQ:      cmd.sq_acc = 1'b1;
            ST_CHECK:
            begin
                cmd.root_start = !stat.sum_small;
                cmd.out_miss   = stat.sum_small && stat.out_free;
            end
            ST_ROOT:    cmd.axis_clr = stat.root_done;
            ST_DT_GO:   cmd.div_start_step = 1'b1;
            ST_DT_WAIT: cmd.wr_step = stat.div_done;
            ST_MUL:     cmd.mul_g = 1'b1;
            ST_DN_GO:   cmd.div_start_next = 1'b1;
            ST_DN_WAIT:
            begin
                cmd.wr_next  = stat.div_done;
                cmd.axis_adv = stat.div_done && !stat.axis_last;
            end
            ST_EMIT:    cmd.out_query = stat.out_free;
            ST_STEP:    cmd.step_exec = stat.walking && stat.out_free;
            default:    cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.out_miss, cmd.out_query, cmd.step_exec}))
        else $error("two result loads at once");

    a_one_div: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_start_step || cmd.div_start_next) |=> !stat.div_done)
        else $error("divider done right after start");

    a_root_follow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.root_start |=> state_reg == ST_ROOT)
        else $error("root started outside setup");

endmodule

/* rtl/voxel_ray_traversal_3d.sv */
// Voxel ray walker (3D DDA over a unit grid, Q15.16 distances).
// Input channel (in_valid/in_ready): op=0 starts a ray with start position,
// direction and max_dist; op=1 answers whether the last queried voxel is solid.
// Output channel (out_valid/out_ready): done_res=0 is a voxel query, done_res=1
// the final result with hit, voxel, entry face and distance.
// After a start's transfer the walker squares and sums the three direction
// components, checks the sum, takes its 32-step bit-pair root, then per axis
// runs two 33-step restoring divides, each launched from its own state, and
// one multiply, and loads its first query once the result register is free.
// A direction whose squared components sum below 11 gives a miss from the check.
// An answer is carried out in the step state, which loads the result register
// once it is free and returns to idle; the walk loop is one nearest-boundary
// compare and saturating add per answer.
// Input is taken only in the idle state; one item is in flight at a time.
// A finished result sits in an output register; a stalled receiver holds the
// walker in its final state until the register frees, and the next input
// transfer may happen while that result waits.
// Reset clears the walk: answers are then dropped with no result.
module voxel_ray_traversal_3d #(
    parameter int MAX_STEPS = vrt_pkg::MAX_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic signed [15:0] dir_z,
    input  logic [30:0]        max_dist,
    input  logic               solid,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               done_res,
    output logic signed [15:0] voxel_x,
    output logic signed [15:0] voxel_y,
    output logic signed [15:0] voxel_z,
    output logic signed [1:0]  face_x,
    output logic signed [1:0]  face_y,
    output logic signed [1:0]  face_z,
    output logic               hit,
    output logic [30:0]        distance
);
    import vrt_pkg::*;

    vrt_cmd_t  cmd;
    vrt_stat_t stat;

    vrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vrt_dp #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .dir_z     (dir_z),
        .max_dist  (max_dist),
        .solid     (solid),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .done_res  (done_res),
        .voxel_x   (voxel_x),
        .voxel_y   (voxel_y),
        .voxel_z   (voxel_z),
        .face_x    (face_x),
        .face_y    (face_y),
        .face_z    (face_z),
        .hit       (hit),
        .distance  (distance)
    );

endmodule
